// ===== rtl/core/fpd_pkg.sv =====
// Shared types and constants for the flight phase detector.
// Holds the phase encoding, configuration register indices and reset values.
// No dependencies.
package fpd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_ASCENT   = 2'd1,
		PH_DESCENT  = 2'd2,
		PH_RECOVERY = 2'd3
	} phase_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CM_BITS        = 16;
	localparam int EVAL_BITS      = 8;
	localparam int FLOOR_BITS     = 24;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_LAUNCH_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_APOGEE_DROP      = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LANDING_BAND     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE_EVALS     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LANDING_EVALS    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BASELINE_FLOOR   = 3'd5;

	localparam logic [CM_BITS-1:0]           RST_LAUNCH_THRESHOLD = 16'd20;
	localparam logic [CM_BITS-1:0]           RST_APOGEE_DROP      = 16'd20;
	localparam logic [CM_BITS-1:0]           RST_LANDING_BAND     = 16'd5;
	localparam logic [EVAL_BITS-1:0]         RST_SETTLE_EVALS     = 8'd10;
	localparam logic [EVAL_BITS-1:0]         RST_LANDING_EVALS    = 8'd20;
	localparam logic signed [FLOOR_BITS-1:0] RST_BASELINE_FLOOR   = -24'sd10000;

endpackage

// ===== rtl/core/flight_phase_detector.sv =====
// Flight phase detector: armed latch, baseline capture, peak tracking and phase steps.
// An accepted input beat reaches its result beat through the input register, then the result
// register. Throughput: one beat per cycle while the result register is empty or m_tready is high;
// the phase update between the two registers is combinational. arst_n clears all state,
// configuration returns to its defaults and both pipeline stages empty. Depends on fpd_pkg.
module flight_phase_detector
	import fpd_pkg::*;
#(
	parameter int ALT_BITS   = 24,
	parameter int COUNT_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// altitude_cm
	input  logic [((ALT_BITS+7)/8)*8-1:0] s_tdata,
	// arm, evaluate
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// phase, armed_now, baseline_valid, relative_altitude_cm, peak_altitude_cm, apogee_fire
	output logic [((2*ALT_BITS+5+7)/8)*8-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int A      = ALT_BITS;
	localparam int OUT_W  = ((2*ALT_BITS+5+7)/8)*8;
	localparam int CW     = ((ALT_BITS > FLOOR_BITS) ? ALT_BITS : FLOOR_BITS) + 2;
	localparam int NW     = ((COUNT_BITS > EVAL_BITS) ? COUNT_BITS : EVAL_BITS) + 1;

	// configuration
	logic [CM_BITS-1:0]           launch_q, drop_q, band_q;
	logic [EVAL_BITS-1:0]         settle_evals_q, land_evals_q;
	logic signed [FLOOR_BITS-1:0] floor_q;

	// state
	logic                  armed_q, taken_q;
	phase_t                phase_q;
	logic [COUNT_BITS-1:0] settle_q, land_q;
	logic signed [A-1:0]   base_q, peak_q;

	// input stage
	logic                valid_s1, arm_s1, eval_s1;
	logic signed [A-1:0] alt_s1;

	// result stage
	logic                valid_s2, armed_s2, taken_s2, fire_s2;
	phase_t              phase_s2;
	logic signed [A-1:0] rel_s2, peak_s2;

	// next state
	logic                  armed_nx, taken_nx, fire_nx;
	phase_t                phase_nx;
	logic [COUNT_BITS-1:0] settle_nx, land_nx, settle_inc, land_inc;
	logic signed [A-1:0]   base_nx, peak_nx, rel_nx, rel_sat;
	logic signed [A:0]     diff, drop;
	logic                  adv2;

	assign cfg_ready = 1'b1;

	assign adv2     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv2;
	assign m_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q       <= RST_LAUNCH_THRESHOLD;
			drop_q         <= RST_APOGEE_DROP;
			band_q         <= RST_LANDING_BAND;
			settle_evals_q <= RST_SETTLE_EVALS;
			land_evals_q   <= RST_LANDING_EVALS;
			floor_q        <= RST_BASELINE_FLOOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LAUNCH_THRESHOLD: launch_q       <= cfg_data[CM_BITS-1:0];
				CFG_APOGEE_DROP:      drop_q         <= cfg_data[CM_BITS-1:0];
				CFG_LANDING_BAND:     band_q         <= cfg_data[CM_BITS-1:0];
				CFG_SETTLE_EVALS:     settle_evals_q <= cfg_data[EVAL_BITS-1:0];
				CFG_LANDING_EVALS:    land_evals_q   <= cfg_data[EVAL_BITS-1:0];
				CFG_BASELINE_FLOOR:   floor_q        <= $signed(cfg_data[FLOOR_BITS-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			arm_s1  <= s_tuser[0];
			eval_s1 <= s_tuser[1];
			alt_s1  <= $signed(s_tdata[A-1:0]);
		end
	end

	// relative altitude against the baseline held before this beat, saturated
	always_comb begin
		diff = $signed({alt_s1[A-1], alt_s1}) - $signed({base_q[A-1], base_q});
		if (diff[A] != diff[A-1]) begin
			rel_sat = diff[A] ? $signed({1'b1, {(A-1){1'b0}}}) : $signed({1'b0, {(A-1){1'b1}}});
		end else begin
			rel_sat = diff[A-1:0];
		end
	end

	assign settle_inc = (settle_q == {COUNT_BITS{1'b1}}) ? settle_q : settle_q + 1'b1;
	assign land_inc   = (land_q == {COUNT_BITS{1'b1}}) ? land_q : land_q + 1'b1;

	always_comb begin
		armed_nx  = armed_q | arm_s1;
		phase_nx  = phase_q;
		settle_nx = settle_q;
		land_nx   = land_q;
		taken_nx  = taken_q;
		base_nx   = base_q;
		peak_nx   = peak_q;
		rel_nx    = '0;
		fire_nx   = 1'b0;
		drop      = '0;
		if (armed_nx) begin
			rel_nx = rel_sat;
			if (rel_sat > peak_q) begin
				peak_nx = rel_sat;
			end
			drop = $signed({peak_nx[A-1], peak_nx}) - $signed({rel_sat[A-1], rel_sat});
			if (eval_s1) begin
				case (phase_q)
					PH_IDLE: begin
						settle_nx = settle_inc;
						if (NW'(settle_inc) > NW'(settle_evals_q)) begin
							if (!taken_q) begin
								base_nx  = alt_s1;
								taken_nx = 1'b1;
								peak_nx  = '0;
							end else if (($signed(CW'(base_q)) > $signed(CW'(floor_q))) &&
									($signed(CW'(rel_sat)) > $signed(CW'(launch_q)))) begin
								phase_nx = PH_ASCENT;
							end
						end
					end
					PH_ASCENT: begin
						if ($signed(CW'(drop)) > $signed(CW'(drop_q))) begin
							phase_nx = PH_DESCENT;
							fire_nx  = 1'b1;
						end
					end
					PH_DESCENT: begin
						if (NW'(land_q) > NW'(land_evals_q)) begin
							phase_nx = PH_RECOVERY;
						end else if ($signed(CW'(rel_sat)) < $signed(CW'(band_q))) begin
							land_nx = land_inc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b0;
			phase_q  <= PH_IDLE;
			settle_q <= '0;
			land_q   <= '0;
			taken_q  <= 1'b0;
			base_q   <= '0;
			peak_q   <= '0;
		end else if (adv2) begin
			armed_q  <= armed_nx;
			phase_q  <= phase_nx;
			settle_q <= settle_nx;
			land_q   <= land_nx;
			taken_q  <= taken_nx;
			base_q   <= base_nx;
			peak_q   <= peak_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// hold the result beat until it is taken
	always_ff @(posedge clk) begin
		if (adv2) begin
			phase_s2 <= phase_nx;
			armed_s2 <= armed_nx;
			taken_s2 <= taken_nx;
			rel_s2   <= rel_nx;
			peak_s2  <= peak_nx;
			fire_s2  <= fire_nx;
		end
	end

	assign m_tdata = OUT_W'({fire_s2, peak_s2, rel_s2, taken_s2, armed_s2, phase_s2});

	a_fire_in_descent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && fire_s2 |-> phase_s2 == PH_DESCENT)
		else $error("apogee beat without descent phase");

	a_unarmed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !armed_s2 |-> rel_s2 == '0 && !fire_s2 && phase_s2 == PH_IDLE)
		else $error("unarmed result carries flight data");

	a_recovery_final: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RECOVERY |=> phase_q == PH_RECOVERY)
		else $error("left recovery phase");

	a_flight_needs_baseline: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> taken_q && armed_q)
		else $error("flight phase without baseline or arming");

	a_peak_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!peak_q[A-1])
		else $error("peak altitude negative");

endmodule
